### hdl/stack_permutation_checker_macros.svh
// Assertion macros used by the checker file spc_checker.sv.
`ifndef STACK_PERMUTATION_CHECKER_MACROS_SVH
`define STACK_PERMUTATION_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spc assertion failed");

`endif

### hdl/spc_pkg.sv
package spc_pkg;

	localparam int MAX_CARS_DEF = 1024;
	localparam int CAR_W        = 11;
	localparam int LEN_W        = 11;
	localparam int NA_W         = 12;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 8;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [CAR_W-1:0] data;
	} spc_shift_t;

endpackage

### hdl/spc_cell.sv
module spc_cell (
	input  logic                      clk,
	input  spc_pkg::spc_shift_t       cmd,
	input  logic [spc_pkg::CAR_W-1:0] up_val,
	input  logic [spc_pkg::CAR_W-1:0] down_val,
	output logic [spc_pkg::CAR_W-1:0] val_q
);

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			val_q <= up_val;
		end else if (cmd.pop) begin
			val_q <= down_val;
		end
	end

endmodule

### hdl/spc_ctrl.sv
module spc_ctrl #(
	parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           seq_len_we,
	input  logic [spc_pkg::LEN_W-1:0]      seq_len_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [spc_pkg::CAR_W-1:0]      car_number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           verdict,
	input  logic [spc_pkg::CAR_W-1:0]      top_val,
	output spc_pkg::spc_shift_t            cmd
);

	localparam int DW = $clog2(MAX_CARS + 1);
	localparam logic ST_TAKE = 1'b0;
	localparam logic ST_PUSH = 1'b1;

	logic                        state_q;
	logic [spc_pkg::LEN_W-1:0]   seq_len_q;
	logic [spc_pkg::NA_W-1:0]    na_q;
	logic [DW-1:0]               depth_q;
	logic [spc_pkg::LEN_W-1:0]   items_q;
	logic                        failed_q;
	logic                        last_q;
	logic                        out_valid_q;
	logic [spc_pkg::CAR_W-1:0]   tgt_q;
	logic                        verdict_q;

	logic [spc_pkg::LEN_W-1:0]   len;
	logic [spc_pkg::NA_W-1:0]    v_ext;
	logic                        out_free;
	logic                        last_now;
	logic                        accept;
	logic                        bad;
	logic                        pass;
	logic                        need_push;
	logic                        pop_ok;
	logic                        take_fail;
	logic                        full;
	logic                        push_last;
	logic                        finish;
	logic                        push_step;
	logic                        emit;
	logic                        emit_val;

	always_comb begin
		priority if (seq_len_q == '0) begin
			len = spc_pkg::LEN_W'(1);
		end else if (32'(seq_len_q) > 32'(MAX_CARS)) begin
			len = spc_pkg::LEN_W'(MAX_CARS);
		end else begin
			len = seq_len_q;
		end
	end

	assign v_ext     = spc_pkg::NA_W'(car_number);
	assign out_free  = !out_valid_q || out_ready;
	assign last_now  = (spc_pkg::NA_W'(items_q) + spc_pkg::NA_W'(1)) >= spc_pkg::NA_W'(len);
	assign in_ready  = (state_q == ST_TAKE) && (!last_now || out_free);
	assign accept    = in_valid && in_ready;

	assign bad       = (car_number == '0) || (car_number > len);
	assign pass      = v_ext >= na_q;
	assign need_push = !failed_q && !bad && pass && (v_ext != na_q);
	assign pop_ok    = (depth_q != '0) && (top_val == car_number);
	assign take_fail = failed_q || bad || (!pass && !pop_ok);

	assign full      = depth_q >= DW'(MAX_CARS);
	assign push_last = (na_q + spc_pkg::NA_W'(1)) == spc_pkg::NA_W'(tgt_q);
	assign finish    = full || push_last;
	assign push_step = (state_q == ST_PUSH) && !(finish && last_q && !out_free);

	assign emit      = (accept && last_now && !need_push) || (push_step && finish && last_q);
	assign emit_val  = (state_q == ST_PUSH) ? full : take_fail;

	assign cmd.push  = push_step && !full;
	assign cmd.pop   = accept && !failed_q && !bad && !pass && pop_ok;
	assign cmd.data  = na_q[spc_pkg::CAR_W-1:0];

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			seq_len_q   <= spc_pkg::LEN_W'(1);
			na_q        <= spc_pkg::NA_W'(1);
			depth_q     <= '0;
			items_q     <= '0;
			failed_q    <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seq_len_we) begin
				seq_len_q <= seq_len_wdata;
			end
			if (emit) begin
				state_q     <= ST_TAKE;
				out_valid_q <= 1'b1;
				na_q        <= spc_pkg::NA_W'(1);
				depth_q     <= '0;
				items_q     <= '0;
				failed_q    <= 1'b0;
			end else begin
				if (out_valid_q && out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (accept) begin
					items_q <= items_q + spc_pkg::LEN_W'(1);
					if (need_push) begin
						state_q <= ST_PUSH;
						last_q  <= last_now;
					end else begin
						failed_q <= take_fail;
						if (!failed_q && !bad && pass) begin
							na_q <= v_ext + spc_pkg::NA_W'(1);
						end
						if (cmd.pop) begin
							depth_q <= depth_q - DW'(1);
						end
					end
				end
				if (push_step) begin
					if (full) begin
						failed_q <= 1'b1;
					end else begin
						depth_q <= depth_q + DW'(1);
						na_q    <= push_last ? spc_pkg::NA_W'(tgt_q) + spc_pkg::NA_W'(1)
							: na_q + spc_pkg::NA_W'(1);
					end
					if (finish) begin
						state_q <= ST_TAKE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q <= car_number;
		end
		if (emit) begin
			verdict_q <= emit_val;
		end
	end

endmodule

### hdl/stack_permutation_checker.sv
// The verdict is registered with the last transfer of a sequence or, if that target pushes cars
// onto the siding, with its final push step; a target that pushes cars holds the input in
// ST_PUSH while it pushes them, and the cell chain takes one push per cycle there. The last
// transfer and the last push of a sequence wait until the verdict output is free.
// Reset: arst_n clears control, counters and seq_len (to 1) at once; siding cells are not reset.
module stack_permutation_checker #(
	parameter int MAX_CARS = spc_pkg::MAX_CARS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             seq_len_we,
	input  logic [spc_pkg::LEN_W-1:0]        seq_len_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [spc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [10:0] car_number
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [spc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [0] verdict
);

	spc_pkg::spc_shift_t         cmd;
	logic                        verdict;
	logic [spc_pkg::CAR_W-1:0]   cell_val [MAX_CARS];

	spc_ctrl #(
		.MAX_CARS (MAX_CARS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.seq_len_we    (seq_len_we),
		.seq_len_wdata (seq_len_wdata),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.car_number    (s_axis_tdata[spc_pkg::CAR_W-1:0]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.verdict       (verdict),
		.top_val       (cell_val[0]),
		.cmd           (cmd)
	);

	for (genvar i = 0; i < MAX_CARS; i++) begin : g_cell
		logic [spc_pkg::CAR_W-1:0] up_val;
		logic [spc_pkg::CAR_W-1:0] down_val;

		if (i == 0) begin : g_top
			assign up_val = cmd.data;
		end else begin : g_mid
			assign up_val = cell_val[i-1];
		end

		if (i == MAX_CARS - 1) begin : g_bot
			assign down_val = cell_val[i];
		end else begin : g_inner
			assign down_val = cell_val[i+1];
		end

		spc_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.up_val   (up_val),
			.down_val (down_val),
			.val_q    (cell_val[i])
		);
	end

	assign m_axis_tdata = {{(spc_pkg::OUT_TDATA_W-1){1'b0}}, verdict};

endmodule

### hdl/spc_checker.sv
`include "stack_permutation_checker_macros.svh"

module spc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [spc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	`SPC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`SPC_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[spc_pkg::OUT_TDATA_W-1:1] == '0)
	`SPC_ASSERT_IMP(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready) || $past(!s_axis_tready))

endmodule

bind stack_permutation_checker spc_checker u_spc_checker (.*);

### bench/stack_permutation_checker_test.sv
`timescale 1ns / 100ps

module stack_permutation_checker_test;
	import spc_pkg::*;

	localparam int RANDOM_CARS = 1200;
	localparam int CALM_AFTER  = 1080;
	localparam int BIG_AFTER   = 40;
	localparam int QUIET_LIMIT = 5000;
	localparam int PLAN_ROWS   = 26;

	typedef enum bit {ROW_CAR, ROW_LEN} row_kind_t;
	typedef enum logic {STACKABLE, NOT_STACKABLE} verdict_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CAR_W-1:0] value;
		bit               typed;
		verdict_t         verdict;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   seq_len_we = 1'b0;
	logic [LEN_W-1:0]       seq_len_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [10:0] car_number
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] verdict

	// siding and sequence state as the block should hold it
	logic [CAR_W-1:0] siding [MAX_CARS_DEF];
	int               siding_depth = 0;
	int               next_in = 1;
	int               cars_taken = 0;
	bit               run_broken = 1'b0;
	logic [LEN_W-1:0] len_reg = 11'd1;

	logic             verdicts_due [$];
	logic [CAR_W-1:0] run_cars [$];
	int               bad_count = 0;
	int               quiet = 0;
	int               gap_pct = 0;
	bit               calm = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_CAR, 1,    1'b1, STACKABLE},
		'{ROW_CAR, 0,    1'b1, NOT_STACKABLE},
		'{ROW_CAR, 2047, 1'b1, NOT_STACKABLE},
		'{ROW_LEN, 0,    1'b0, STACKABLE},
		'{ROW_CAR, 1,    1'b1, STACKABLE},
		'{ROW_CAR, 2,    1'b1, NOT_STACKABLE},
		'{ROW_LEN, 3,    1'b0, STACKABLE},
		'{ROW_CAR, 3,    1'b0, STACKABLE},
		'{ROW_CAR, 1,    1'b0, STACKABLE},
		'{ROW_CAR, 2,    1'b1, NOT_STACKABLE},
		'{ROW_CAR, 3,    1'b0, STACKABLE},
		'{ROW_CAR, 2,    1'b0, STACKABLE},
		'{ROW_CAR, 1,    1'b1, STACKABLE},
		'{ROW_CAR, 1,    1'b0, STACKABLE},
		'{ROW_CAR, 2,    1'b0, STACKABLE},
		'{ROW_CAR, 3,    1'b1, STACKABLE},
		'{ROW_CAR, 2,    1'b0, STACKABLE},
		'{ROW_CAR, 1,    1'b0, STACKABLE},
		'{ROW_CAR, 3,    1'b1, STACKABLE},
		'{ROW_CAR, 1,    1'b0, STACKABLE},
		'{ROW_CAR, 4,    1'b0, STACKABLE},
		'{ROW_CAR, 2,    1'b1, NOT_STACKABLE},
		'{ROW_LEN, 2,    1'b0, STACKABLE},
		'{ROW_CAR, 2,    1'b0, STACKABLE},
		'{ROW_LEN, 1,    1'b0, STACKABLE},
		'{ROW_CAR, 1,    1'b0, STACKABLE}
	};

	stack_permutation_checker DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.seq_len_we    (seq_len_we),
		.seq_len_wdata (seq_len_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic int cars_per_run();
		int n;
		n = len_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_CARS_DEF)
			n = MAX_CARS_DEF;
		return n;
	endfunction

	// returns 1 when this car closes the sequence
	function automatic bit judge_car(input logic [CAR_W-1:0] car, output logic verdict);
		int len;
		int v;
		len = cars_per_run();
		v = car;
		verdict = 1'b0;
		if (!run_broken) begin
			if (v == 0 || v > len) begin
				run_broken = 1'b1;
			end else if (v >= next_in) begin
				while (next_in < v && !run_broken) begin
					if (siding_depth >= MAX_CARS_DEF) begin
						run_broken = 1'b1;
					end else begin
						siding[siding_depth] = CAR_W'(next_in);
						siding_depth++;
						next_in++;
					end
				end
				if (!run_broken)
					next_in = v + 1;
			end else if (siding_depth > 0 && siding[siding_depth-1] == CAR_W'(v)) begin
				siding_depth--;
			end else begin
				run_broken = 1'b1;
			end
		end
		cars_taken++;
		if (cars_taken >= len) begin
			verdict = run_broken;
			siding_depth = 0;
			next_in = 1;
			cars_taken = 0;
			run_broken = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// a departure order that a single siding can produce
	function automatic void build_order(input int n, input int push_pct);
		int               arriving;
		logic [CAR_W-1:0] held [$];
		logic [CAR_W-1:0] moved;
		arriving = 1;
		run_cars.delete();
		while (run_cars.size() < n) begin
			if (arriving <= n && (held.size() == 0 || $urandom_range(0, 99) < push_pct)) begin
				held = {held, CAR_W'(arriving)};
				arriving++;
			end else begin
				moved = held.pop_back();
				run_cars = {run_cars, moved};
			end
		end
	endfunction

	task automatic send_car(input logic [CAR_W-1:0] car, input bit typed, input verdict_t typed_verdict);
		logic verdict;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - CAR_W){1'b0}}, car};
		do @(posedge clk); while (!s_axis_tready);
		if (judge_car(car, verdict))
			verdicts_due = {verdicts_due, typed ? logic'(typed_verdict) : verdict};
	endtask

	task automatic send_run();
		foreach (run_cars[i])
			send_car(run_cars[i], 1'b0, STACKABLE);
	endtask

	// hold the sender until the block has drained, then write the length
	task automatic set_len(input logic [LEN_W-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (cars_per_run() + 8) @(posedge clk);
		seq_len_we <= 1'b1;
		seq_len_wdata <= value;
		@(posedge clk);
		seq_len_we <= 1'b0;
		len_reg = value;
	endtask

	initial begin : ready_pattern
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict: expected none, got %0d", m_axis_tdata[0]);
					bad_count++;
				end else if (m_axis_tdata[0] !== verdicts_due[0]) begin
					$error("verdict: expected %0d, got %0d", verdicts_due[0], m_axis_tdata[0]);
					bad_count++;
					void'(verdicts_due.pop_front());
				end else begin
					void'(verdicts_due.pop_front());
				end
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int               random_cars;
		int               pick;
		int               n;
		int               kind;
		int               a;
		int               b;
		bit               big_done;
		logic [CAR_W-1:0] swap;

		random_cars = 0;
		big_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_LEN)
				set_len(plan[r].value);
			else
				send_car(plan[r].value, plan[r].typed, plan[r].verdict);
		end

		while (random_cars < RANDOM_CARS) begin
			calm = (random_cars >= CALM_AFTER);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			if (calm)
				gap_pct = 0;
			pick = $urandom_range(0, 19);
			if (!big_done && random_cars >= BIG_AFTER) begin
				// widest register value, one full-length deep run
				set_len(11'd2047);
				build_order(MAX_CARS_DEF, 80);
				send_run();
				random_cars += run_cars.size();
				big_done = 1'b1;
			end else if (pick < 2) begin
				// long length left unfinished, cut short by the next write
				set_len(pick == 0 ? 11'd1024 : LEN_W'($urandom_range(13, 2047)));
				repeat ($urandom_range(1, 6)) begin
					send_car(CAR_W'($urandom_range(0, 1) ? $urandom_range(1, 40)
						: $urandom_range(0, 2047)), 1'b0, STACKABLE);
					random_cars++;
				end
			end else begin
				set_len(pick == 2 ? 11'd0 : LEN_W'($urandom_range(1, 12)));
				n = cars_per_run();
				repeat ($urandom_range(2, 8)) begin
					kind = $urandom_range(0, 9);
					build_order(n, $urandom_range(10, 90));
					if (kind == 6 || kind == 7) begin
						for (a = n - 1; a > 0; a--) begin
							b = $urandom_range(0, a);
							swap = run_cars[a];
							run_cars[a] = run_cars[b];
							run_cars[b] = swap;
						end
					end else if (kind == 8) begin
						a = $urandom_range(0, n - 1);
						case ($urandom_range(0, 2))
							0: run_cars[a] = '0;
							1: run_cars[a] = CAR_W'(n + 1);
							default: run_cars[a] = CAR_W'($urandom_range(0, 2047));
						endcase
					end else if (kind == 9 && n > 1) begin
						run_cars[$urandom_range(0, n - 1)] = run_cars[$urandom_range(0, n - 1)];
					end
					send_run();
					random_cars += run_cars.size();
				end
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 2)) begin
						send_car(CAR_W'($urandom_range(0, 2047)), 1'b0, STACKABLE);
						random_cars++;
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (cars_per_run() + 8) @(posedge clk);
		if (bad_count == 0 && verdicts_due.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
